[rtl/core/sis_pkg.sv]
// ----------------------------------------------------------------------------
// sis_pkg
// Shared constants, codes and types of the sparse index set.
// ----------------------------------------------------------------------------
package sis_pkg;

   localparam int UNIVERSE  = 1024;
   localparam int VAL_W     = 10;
   localparam int CNT_W     = 11;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 24;

   typedef enum logic [2:0] {
      FN_ADD    = 3'd0,
      FN_REMOVE = 3'd1,
      FN_TEST   = 3'd2,
      FN_CLEAR  = 3'd3,
      FN_POP    = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_MISSING = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_VERIFY,
      S_MOVE
   } state_type;

   typedef struct packed {
      logic [2:0]       func;
      logic [VAL_W-1:0] value;
      logic [VAL_W-1:0] pick;
   } req_type;

   typedef struct packed {
      logic             present;
      logic [VAL_W-1:0] popped;
      logic [CNT_W-1:0] count;
      status_type       status;
   } rsp_type;

   typedef struct packed {
      logic ready;
      logic done;
   } eng_ctl_type;

endpackage

[rtl/core/sparse_index_set.sv]
// ----------------------------------------------------------------------------
// sparse_index_set
// Sparse set over 0..1023 with a dense member list and a position table.
// ----------------------------------------------------------------------------
// From accept to result beat: clear, unused codes and out-of-range pop answer
// from idle; test, add and remove of a non-member pass check and verify; pop
// passes check and move; remove of a member passes check, verify and move.
// These chain reads of the position and member list memories. A new request is
// taken only in idle, once the last is done and the result register is free or being read.
// After reset all 1024 position entries are cleared in turn; no beat is taken.
module sparse_index_set (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [sis_pkg::REQ_W-1:0] req_tdata,  // func[2:0], value[12:3], pick_index[22:13]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [sis_pkg::RSP_W-1:0] rsp_tdata   // present[0], popped_value[10:1],
                                                 // member_count[21:11], status[23:22]
);
   import sis_pkg::*;

   req_type     req;
   rsp_type     result;
   eng_ctl_type ctl;
   logic        start;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   assign req.func   = req_tdata[2:0];
   assign req.value  = req_tdata[12:3];
   assign req.pick   = req_tdata[22:13];

   assign req_tready = ctl.ready && (!rsp_valid_ff || rsp_tready);
   assign start      = req_tvalid && req_tready;

   sis_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req),
      .ctl    (ctl),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (ctl.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {result.status, result.count, result.popped, result.present};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.done |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result beat overwritten while held");
`endif

endmodule

[rtl/core/sis_engine.sv]
// ----------------------------------------------------------------------------
// sis_engine
// Position and member memories with the read-modify-write sequencer.
// ----------------------------------------------------------------------------
module sis_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  sis_pkg::req_type     req,
   output sis_pkg::eng_ctl_type ctl,
   output sis_pkg::rsp_type     result
);
   import sis_pkg::*;

   logic [VAL_W-1:0] pos_mem  [UNIVERSE];
   logic [VAL_W-1:0] list_mem [UNIVERSE];

   state_type        state_ff, state_in;
   logic [VAL_W-1:0] init_ff, init_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [2:0]       func_ff, func_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [VAL_W-1:0] slot_ff, slot_in;
   logic [VAL_W-1:0] victim_ff, victim_in;
   logic [VAL_W-1:0] pos_q_ff, list_q_ff;

   logic             pos_we, list_we;
   logic [VAL_W-1:0] pos_wa, pos_wd, list_wa, list_wd, list_ra;
   logic [CNT_W-1:0] total_m1;
   logic             member;

   assign total_m1 = total_ff - CNT_W'(1);
   assign member   = ({1'b0, slot_ff} < total_ff) && (list_q_ff == value_ff);

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_wa] <= pos_wd;
      pos_q_ff <= pos_mem[req.value];
   end

   always_ff @(posedge clock) begin
      if (list_we) list_mem[list_wa] <= list_wd;
      list_q_ff <= list_mem[list_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff  <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      value_ff  <= value_in;
      slot_ff   <= slot_in;
      victim_ff <= victim_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT:   if (init_ff == VAL_W'(UNIVERSE - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (start) begin
               case (req.func)
                  FN_ADD, FN_REMOVE, FN_TEST: state_in = S_CHECK;
                  FN_POP: if ({1'b0, req.pick} < total_ff) state_in = S_CHECK;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CHECK:  state_in = (func_ff == FN_POP) ? S_MOVE : S_VERIFY;
         S_VERIFY: state_in = (func_ff == FN_REMOVE && member) ? S_MOVE : S_IDLE;
         S_MOVE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      init_in   = init_ff;
      total_in  = total_ff;
      func_in   = func_ff;
      value_in  = value_ff;
      slot_in   = slot_ff;
      victim_in = victim_ff;
      pos_we    = 1'b0;
      pos_wa    = init_ff;
      pos_wd    = '0;
      list_we   = 1'b0;
      list_wa   = slot_ff;
      list_wd   = list_q_ff;
      list_ra   = total_m1[VAL_W-1:0];
      ctl.ready = 1'b0;
      ctl.done  = 1'b0;
      result.present = 1'b0;
      result.popped  = '0;
      result.status  = ST_OK;
      case (state_ff)
         S_INIT: begin
            pos_we  = 1'b1;
            init_in = init_ff + VAL_W'(1);
         end
         S_IDLE: begin
            ctl.ready = 1'b1;
            list_ra   = req.pick;
            if (start) begin
               func_in  = req.func;
               value_in = req.value;
               slot_in  = req.pick;
               case (req.func)
                  FN_ADD, FN_REMOVE, FN_TEST: ctl.done = 1'b0;
                  FN_CLEAR: begin
                     total_in = '0;
                     ctl.done = 1'b1;
                  end
                  FN_POP: begin
                     if ({1'b0, req.pick} >= total_ff) begin
                        ctl.done      = 1'b1;
                        result.status = ST_RANGE;
                     end
                  end
                  default: ctl.done = 1'b1;
               endcase
            end
         end
         S_CHECK: begin
            if (func_ff == FN_POP) begin
               victim_in = list_q_ff;
            end else begin
               slot_in = pos_q_ff;
               list_ra = pos_q_ff;
            end
         end
         S_VERIFY: begin
            case (func_ff)
               FN_TEST: begin
                  ctl.done       = 1'b1;
                  result.present = member;
               end
               FN_ADD: begin
                  ctl.done = 1'b1;
                  if (member) begin
                     result.status = ST_DUP;
                  end else begin
                     pos_we   = 1'b1;
                     pos_wa   = value_ff;
                     pos_wd   = total_ff[VAL_W-1:0];
                     list_we  = 1'b1;
                     list_wa  = total_ff[VAL_W-1:0];
                     list_wd  = value_ff;
                     total_in = total_ff + CNT_W'(1);
                  end
               end
               default: begin
                  if (!member) begin
                     ctl.done      = 1'b1;
                     result.status = ST_MISSING;
                  end
               end
            endcase
         end
         S_MOVE: begin
            ctl.done = 1'b1;
            pos_we   = 1'b1;
            pos_wa   = list_q_ff;
            pos_wd   = slot_ff;
            list_we  = 1'b1;
            total_in = total_m1;
            if (func_ff == FN_POP) result.popped = victim_ff;
         end
         default: ctl.done = 1'b0;
      endcase
      result.count = total_in;
   end

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(UNIVERSE))
      else $error("member count beyond universe");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("request taken outside idle");

   a_move_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOVE |=> total_ff == $past(total_ff) - CNT_W'(1))
      else $error("move did not shrink the count");
`endif

endmodule

[verif/sparse_index_set_tb.sv]
// ----------------------------------------------------------------------------
// sparse_index_set_tb
// Drives add, remove, membership test, clear, pop and unused request codes
// into the sparse index set with random gaps on the request stream and
// random stalls on the response stream. A shadow copy of the member list,
// the position table and the count predicts every response beat, which is
// then checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module sparse_index_set_tb;
   import sis_pkg::*;

   localparam logic [2:0] FN_SPARE5 = 3'd5;
   localparam logic [2:0] FN_SPARE6 = 3'd6;
   localparam logic [2:0] FN_SPARE7 = 3'd7;

   typedef struct {
      logic [2:0]       func;
      logic [VAL_W-1:0] value;
      logic [VAL_W-1:0] pick;
      int               gap;
      bit               drain;
   } set_request_type;

   typedef struct {
      logic             present;
      logic [VAL_W-1:0] popped;
      logic [CNT_W-1:0] count;
      logic [1:0]       status;
   } set_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   sparse_index_set dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   set_request_type pending_requests[$];
   set_result_type  expected_results[$];
   set_request_type current_request;
   int              request_total = 0;
   int              accepted_count = 0;
   int              error_count = 0;
   int              send_gap = 0;
   int              stall_left = 0;
   int              cycle_no = 0;

   bit               in_set[UNIVERSE];
   logic [CNT_W-1:0] slot_of[UNIVERSE];
   logic [VAL_W-1:0] roster[UNIVERSE];
   int unsigned      roster_len = 0;

   bit gen_has[UNIVERSE];
   int gen_count = 0;

   always #4 clock = ~clock;

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 3);
      if (r < 9) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic void drop_from_roster(logic [VAL_W-1:0] v);
      logic [CNT_W-1:0] p;
      logic [VAL_W-1:0] last;
      p = slot_of[v];
      last = roster[roster_len - 1];
      roster[p] = last;
      slot_of[last] = p;
      in_set[v] = 1'b0;
      roster_len--;
   endfunction

   function automatic set_result_type apply_set_request(set_request_type rq);
      set_result_type rs;
      rs.present = 1'b0;
      rs.popped = '0;
      rs.status = ST_OK;
      case (rq.func)
         FN_ADD: begin
            if (in_set[rq.value]) begin
               rs.status = ST_DUP;
            end else begin
               slot_of[rq.value] = CNT_W'(roster_len);
               in_set[rq.value] = 1'b1;
               roster[roster_len] = rq.value;
               roster_len++;
            end
         end
         FN_REMOVE: begin
            if (!in_set[rq.value]) rs.status = ST_MISSING;
            else drop_from_roster(rq.value);
         end
         FN_TEST: begin
            rs.present = in_set[rq.value];
         end
         FN_CLEAR: begin
            for (int i = 0; i < roster_len; i++) in_set[roster[i]] = 1'b0;
            roster_len = 0;
         end
         FN_POP: begin
            if (rq.pick >= roster_len) begin
               rs.status = ST_RANGE;
            end else begin
               rs.popped = roster[rq.pick];
               drop_from_roster(rs.popped);
            end
         end
         default: begin
         end
      endcase
      rs.count = CNT_W'(roster_len);
      return rs;
   endfunction

   task automatic queue_request(logic [2:0] func, logic [VAL_W-1:0] value,
                                logic [VAL_W-1:0] pick, int gap, bit drain);
      set_request_type rq;
      rq.func = func;
      rq.value = value;
      rq.pick = pick;
      rq.gap = gap;
      rq.drain = drain;
      pending_requests.insert(pending_requests.size(), rq);
      request_total++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.insert(expected_results.size(),
                                    apply_set_request(current_request));
            accepted_count++;
            send_gap = current_request.gap;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain && expected_results.size() > 0)) begin
               current_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, current_request.pick, current_request.value,
                             current_request.func};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      set_result_type want;
      set_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         cycle_no++;
         if (rsp_tvalid && rsp_tready) begin
            got.present = rsp_tdata[0];
            got.popped = rsp_tdata[10:1];
            got.count = rsp_tdata[21:11];
            got.status = rsp_tdata[23:22];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.present !== want.present) begin
                  $display("%0t: present expected %0d actual %0d",
                           $time, want.present, got.present);
                  error_count++;
               end
               if (got.popped !== want.popped) begin
                  $display("%0t: popped_value expected %0d actual %0d",
                           $time, want.popped, got.popped);
                  error_count++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: member_count expected %0d actual %0d",
                           $time, want.count, got.count);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (((cycle_no >> 8) % 3) != 0 && $urandom_range(0, 3) == 0)
               stall_left = gap_length();
         end
      end
   end

   initial begin
      int               roll;
      int               t_add;
      int               t_rem;
      int               t_test;
      int               t_pop;
      int               gap;
      bit               grow;
      bit               quiet;
      logic [VAL_W-1:0] pool_mask;
      logic [VAL_W-1:0] pool_base;
      logic [VAL_W-1:0] v;
      logic [VAL_W-1:0] pk;

      // empty set, duplicates, range errors, last-slot and middle-slot moves
      queue_request(FN_TEST,   10'd5,    10'd0,    0, 1'b0);
      queue_request(FN_REMOVE, 10'd7,    10'd1023, 0, 1'b0);
      queue_request(FN_POP,    10'd0,    10'd0,    0, 1'b0);
      queue_request(FN_ADD,    10'd0,    10'd0,    0, 1'b0);
      queue_request(FN_ADD,    10'd1023, 10'd1023, 0, 1'b0);
      queue_request(FN_ADD,    10'd0,    10'd0,    2, 1'b0);
      queue_request(FN_ADD,    10'd512,  10'd0,    0, 1'b0);
      queue_request(FN_TEST,   10'd1023, 10'd0,    0, 1'b0);
      queue_request(FN_TEST,   10'd5,    10'd0,    0, 1'b0);
      queue_request(FN_POP,    10'd0,    10'd1023, 0, 1'b0);
      queue_request(FN_POP,    10'd0,    10'd3,    1, 1'b0);
      queue_request(FN_REMOVE, 10'd0,    10'd0,    0, 1'b0);
      queue_request(FN_TEST,   10'd0,    10'd0,    0, 1'b0);
      queue_request(FN_POP,    10'd0,    10'd1,    0, 1'b0);
      queue_request(FN_ADD,    10'd341,  10'd0,    0, 1'b0);
      queue_request(FN_ADD,    10'd682,  10'd0,    0, 1'b0);
      queue_request(FN_POP,    10'd0,    10'd0,    0, 1'b0);
      queue_request(FN_CLEAR,  10'd1023, 10'd1023, 0, 1'b0);
      queue_request(FN_TEST,   10'd682,  10'd0,    0, 1'b0);
      queue_request(FN_ADD,    10'd341,  10'd0,    0, 1'b0);
      queue_request(FN_SPARE5, 10'd1023, 10'd1023, 0, 1'b0);
      queue_request(FN_SPARE6, 10'd341,  10'd0,    0, 1'b0);
      queue_request(FN_SPARE7, 10'd0,    10'd1023, 0, 1'b0);
      queue_request(FN_REMOVE, 10'd341,  10'd0,    0, 1'b0);
      queue_request(FN_CLEAR,  10'd0,    10'd0,    0, 1'b0);

      for (int round = 0; round < 7; round++) begin
         grow = (round % 2) == 0;
         quiet = (round == 2) || (round == 5);
         case (round % 4)
            0: pool_mask = 10'h00f;
            1: pool_mask = 10'h03f;
            2: pool_mask = 10'h0ff;
            default: pool_mask = 10'h3ff;
         endcase
         pool_base = VAL_W'($urandom_range(0, 1023));
         pool_base = pool_base & ~pool_mask;
         t_add = grow ? 45 : 20;
         t_rem = t_add + (grow ? 15 : 30);
         t_test = t_rem + 15;
         t_pop = grow ? 94 : 95;
         for (int k = 0; k < 85; k++) begin
            roll = $urandom_range(0, 99);
            v = pool_base | (VAL_W'($urandom_range(0, 1023)) & pool_mask);
            pk = VAL_W'($urandom_range(0, 1023));
            gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : gap_length();
            if (roll < t_add) begin
               queue_request(FN_ADD, v, pk, gap, 1'b0);
               if (!gen_has[v]) begin
                  gen_has[v] = 1'b1;
                  gen_count++;
               end
            end else if (roll < t_rem) begin
               queue_request(FN_REMOVE, v, pk, gap, 1'b0);
               if (gen_has[v]) begin
                  gen_has[v] = 1'b0;
                  gen_count--;
               end
            end else if (roll < t_test) begin
               queue_request(FN_TEST, v, pk, gap, 1'b0);
            end else if (roll < t_pop) begin
               if (gen_count > 0 && $urandom_range(0, 9) < 7)
                  pk = VAL_W'($urandom_range(0, (gen_count > 1024 ? 1024 : gen_count) - 1));
               queue_request(FN_POP, v, pk, gap, 1'b0);
               if (gen_count > 0 && pk < gen_count) gen_count--;
            end else if (roll < t_pop + 2) begin
               queue_request(FN_CLEAR, v, pk, gap, 1'b0);
               gen_has = '{default: 1'b0};
               gen_count = 0;
            end else begin
               queue_request(3'($urandom_range(5, 7)), v, pk, gap, 1'b0);
            end
         end
         // hold the stream until all responses so far have drained
         if (round == 3) queue_request(FN_TEST, v, pk, 0, 1'b1);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_count == request_total && expected_results.size() == 0);
      repeat (16) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
